// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the list manager RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dllm_pkg.sv
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and constants of the doubly linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    // Default pool size
    localparam int NODES_DEF = 64;

    // Fixed widths of the channel fields
    localparam int CMD_W  = 4;
    localparam int NODE_W = 6;
    localparam int ANCH_W = 7;
    localparam int RES_W  = 7;
    localparam int FL_W   = 6;
    localparam int CNT_W  = 7;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT      = 4'd0,
        CMD_CLEAR     = 4'd1,
        CMD_ADD_FIRST = 4'd2,
        CMD_ADD_LAST  = 4'd3,
        CMD_REM_FIRST = 4'd4,
        CMD_INS_AFTER = 4'd5,
        CMD_REMOVE    = 4'd6,
        CMD_NEXT      = 4'd7,
        CMD_PREV      = 4'd8
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EXEC2,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// File: rtl/core/dllm_ram.sv
// ----------------------------------------------------------------------------
// dllm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dllm_ctrl.sv
// ----------------------------------------------------------------------------
// dllm_ctrl
// Command sequencer: reads, modifies and writes back the link memories,
// keeps the sentinel links and node count, and holds the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dllm_ctrl
    import dllm_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    localparam int LW   = $clog2(NODES + 1),
    localparam int AW   = $clog2(NODES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node,
    input  logic [ANCH_W-1:0] i_anchor,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RES_W-1:0]  o_result_node,
    output logic              o_result_present,
    output logic [FL_W-1:0]   o_first_node,
    output logic [FL_W-1:0]   o_last_node,
    output logic              o_list_empty,
    output logic [CNT_W-1:0]  o_node_count,
    output logic              o_count_error,
    // forward link memory
    output logic              o_nx_we,
    output logic [AW-1:0]     o_nx_waddr,
    output logic [LW-1:0]     o_nx_wdata,
    output logic [AW-1:0]     o_nx_raddr,
    input  logic [LW-1:0]     i_nx_rdata,
    // backward link memory
    output logic              o_pv_we,
    output logic [AW-1:0]     o_pv_waddr,
    output logic [LW-1:0]     o_pv_wdata,
    output logic [AW-1:0]     o_pv_raddr,
    input  logic [LW-1:0]     i_pv_rdata
);

    localparam logic [LW-1:0] SENT = LW'(NODES);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [LW-1:0]    r_node, n_node;
    logic [LW-1:0]    r_anchor, n_anchor;
    logic [LW-1:0]    r_tmp, n_tmp;
    logic [LW-1:0]    r_k, n_k;
    logic [LW-1:0]    r_head_first, n_head_first;
    logic [LW-1:0]    r_head_last, n_head_last;
    logic [LW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_res, n_res;
    logic             r_present, n_present;
    logic             r_err, n_err;

    logic             r_o_valid, n_o_valid;
    logic [RES_W-1:0] r_o_res, n_o_res;
    logic             r_o_present, n_o_present;
    logic [FL_W-1:0]  r_o_first, n_o_first;
    logic [FL_W-1:0]  r_o_last, n_o_last;
    logic             r_o_empty, n_o_empty;
    logic [CNT_W-1:0] r_o_count, n_o_count;
    logic             r_o_err, n_o_err;

    logic             in_acc;
    logic             out_free;

    assign in_acc   = (r_state == ST_IDLE) && i_valid;
    assign out_free = !r_o_valid || !i_stall;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head_first <= SENT;
            r_head_last  <= SENT;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_first <= n_head_first;
            r_head_last  <= n_head_last;
            r_count      <= n_count;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_node      <= n_node;
        r_anchor    <= n_anchor;
        r_tmp       <= n_tmp;
        r_k         <= n_k;
        r_res       <= n_res;
        r_present   <= n_present;
        r_err       <= n_err;
        r_o_res     <= n_o_res;
        r_o_present <= n_o_present;
        r_o_first   <= n_o_first;
        r_o_last    <= n_o_last;
        r_o_empty   <= n_o_empty;
        r_o_count   <= n_o_count;
        r_o_err     <= n_o_err;
    end

    // Sequencer: next state, link memory accesses, head and count updates
    always_comb begin
        t_cmd          cmd_in;
        logic          node_ok;
        logic          anch_ok;
        logic [LW-1:0] nd_in;
        logic [LW-1:0] an_in;
        logic [LW-1:0] lnk_a;
        logic [LW-1:0] lnk_b;

        cmd_in  = t_cmd'(i_command);
        node_ok = int'(i_node) < NODES;
        anch_ok = int'(i_anchor) <= NODES;
        nd_in   = LW'(i_node);
        an_in   = LW'(i_anchor);
        lnk_a   = '0;
        lnk_b   = '0;

        n_state      = r_state;
        n_cmd        = r_cmd;
        n_node       = r_node;
        n_anchor     = r_anchor;
        n_tmp        = r_tmp;
        n_k          = r_k;
        n_head_first = r_head_first;
        n_head_last  = r_head_last;
        n_count      = r_count;
        n_res        = r_res;
        n_present    = r_present;
        n_err        = r_err;

        o_nx_we    = 1'b0;
        o_nx_waddr = '0;
        o_nx_wdata = '0;
        o_nx_raddr = '0;
        o_pv_we    = 1'b0;
        o_pv_waddr = '0;
        o_pv_wdata = '0;
        o_pv_raddr = '0;

        // output word: taken, then possibly reloaded below
        n_o_valid   = r_o_valid && i_stall;
        n_o_res     = r_o_res;
        n_o_present = r_o_present;
        n_o_first   = r_o_first;
        n_o_last    = r_o_last;
        n_o_empty   = r_o_empty;
        n_o_count   = r_o_count;
        n_o_err     = r_o_err;

        unique case (r_state)
            // take a command and issue its first reads
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd     = cmd_in;
                    n_node    = nd_in;
                    n_anchor  = an_in;
                    n_res     = '0;
                    n_present = 1'b0;
                    n_err     = 1'b0;
                    n_state   = ST_DONE;
                    unique case (cmd_in)
                        CMD_INIT, CMD_ADD_LAST: begin
                            if (node_ok) n_state = ST_EXEC;
                        end
                        CMD_CLEAR: begin
                            n_tmp      = r_head_first;
                            n_k        = r_count;
                            o_nx_raddr = AW'(r_head_first);
                            n_state    = ST_WALK;
                        end
                        CMD_ADD_FIRST: begin
                            o_pv_raddr = AW'(r_head_first);
                            if (node_ok) n_state = ST_EXEC;
                        end
                        CMD_REM_FIRST: begin
                            o_nx_raddr = AW'(r_head_first);
                            if (r_count != '0) n_state = ST_EXEC;
                        end
                        CMD_INS_AFTER: begin
                            o_nx_raddr = AW'(an_in);
                            if (node_ok && anch_ok) n_state = ST_EXEC;
                        end
                        CMD_REMOVE, CMD_NEXT, CMD_PREV: begin
                            o_nx_raddr = AW'(nd_in);
                            o_pv_raddr = AW'(nd_in);
                            if (node_ok) n_state = ST_EXEC;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end

            // read data back: first round of writes
            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_cmd)
                    CMD_INIT: begin
                        o_nx_we    = 1'b1;
                        o_nx_waddr = AW'(r_node);
                        o_nx_wdata = r_node;
                        o_pv_we    = 1'b1;
                        o_pv_waddr = AW'(r_node);
                        o_pv_wdata = r_node;
                    end
                    CMD_ADD_FIRST: begin
                        // lnk_a: old first, lnk_b: its backward link
                        lnk_a      = r_head_first;
                        lnk_b      = (lnk_a == SENT) ? r_head_last : i_pv_rdata;
                        o_pv_we    = 1'b1;
                        o_pv_waddr = AW'(r_node);
                        o_pv_wdata = lnk_b;
                        o_nx_we    = 1'b1;
                        o_nx_waddr = AW'(r_node);
                        o_nx_wdata = lnk_a;
                        n_tmp      = lnk_a;
                        n_state    = ST_EXEC2;
                    end
                    CMD_ADD_LAST: begin
                        o_nx_we    = 1'b1;
                        o_nx_waddr = AW'(r_node);
                        o_nx_wdata = SENT;
                        o_pv_we    = 1'b1;
                        o_pv_waddr = AW'(r_node);
                        o_pv_wdata = r_head_last;
                        n_tmp      = r_head_last;
                        n_state    = ST_EXEC2;
                    end
                    CMD_REM_FIRST: begin
                        lnk_a = r_head_first;
                        lnk_b = (lnk_a == SENT) ? r_head_first : i_nx_rdata;
                        if (lnk_b == SENT) begin
                            n_head_last = SENT;
                        end else begin
                            o_pv_we    = 1'b1;
                            o_pv_waddr = AW'(lnk_b);
                            o_pv_wdata = SENT;
                        end
                        n_head_first = lnk_b;
                        n_count      = r_count - LW'(1);
                        n_res        = lnk_a;
                        n_present    = 1'b1;
                    end
                    CMD_INS_AFTER: begin
                        lnk_b      = (r_anchor == SENT) ? r_head_first : i_nx_rdata;
                        o_pv_we    = 1'b1;
                        o_pv_waddr = AW'(r_node);
                        o_pv_wdata = r_anchor;
                        o_nx_we    = 1'b1;
                        o_nx_waddr = AW'(r_node);
                        o_nx_wdata = lnk_b;
                        n_tmp      = lnk_b;
                        n_state    = ST_EXEC2;
                    end
                    CMD_REMOVE: begin
                        // lnk_a: predecessor, lnk_b: successor
                        lnk_a = i_pv_rdata;
                        lnk_b = i_nx_rdata;
                        if (lnk_a == SENT) begin
                            n_head_first = lnk_b;
                        end else begin
                            o_nx_we    = 1'b1;
                            o_nx_waddr = AW'(lnk_a);
                            o_nx_wdata = lnk_b;
                        end
                        if (lnk_b == SENT) begin
                            n_head_last = lnk_a;
                        end else begin
                            o_pv_we    = 1'b1;
                            o_pv_waddr = AW'(lnk_b);
                            o_pv_wdata = lnk_a;
                        end
                        if (r_count == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_count = r_count - LW'(1);
                        end
                        n_res     = r_node;
                        n_present = 1'b1;
                    end
                    CMD_NEXT, CMD_PREV: begin
                        lnk_a = (r_cmd == CMD_NEXT) ? i_nx_rdata : i_pv_rdata;
                        if (lnk_a != r_node) begin
                            n_res     = lnk_a;
                            n_present = 1'b1;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end

            // second round: relink the neighbour, move the head, count up
            ST_EXEC2: begin
                n_state = ST_DONE;
                unique case (r_cmd)
                    CMD_ADD_FIRST: begin
                        if (r_tmp == SENT) begin
                            n_head_last = r_node;
                        end else begin
                            o_pv_we    = 1'b1;
                            o_pv_waddr = AW'(r_tmp);
                            o_pv_wdata = r_node;
                        end
                        n_head_first = r_node;
                    end
                    CMD_ADD_LAST: begin
                        if (r_tmp == SENT) begin
                            n_head_first = r_node;
                        end else begin
                            o_nx_we    = 1'b1;
                            o_nx_waddr = AW'(r_tmp);
                            o_nx_wdata = r_node;
                        end
                        n_head_last = r_node;
                    end
                    default: begin
                        if (r_tmp == SENT) begin
                            n_head_last = r_node;
                        end else begin
                            o_pv_we    = 1'b1;
                            o_pv_waddr = AW'(r_tmp);
                            o_pv_wdata = r_node;
                        end
                        if (r_anchor == SENT) begin
                            n_head_first = r_node;
                        end else begin
                            o_nx_we    = 1'b1;
                            o_nx_waddr = AW'(r_anchor);
                            o_nx_wdata = r_node;
                        end
                    end
                endcase
                if (r_count >= SENT) begin
                    n_err = 1'b1;
                end else begin
                    n_count = r_count + LW'(1);
                end
            end

            // clear walk: one node per cycle along the forward links
            ST_WALK: begin
                if (r_k == '0) begin
                    n_head_first = SENT;
                    n_head_last  = SENT;
                    n_count      = '0;
                    n_state      = ST_DONE;
                end else begin
                    lnk_a = (r_tmp == SENT) ? r_head_first : i_nx_rdata;
                    if (r_tmp == SENT) begin
                        n_head_first = SENT;
                        n_head_last  = SENT;
                    end else begin
                        o_nx_we    = 1'b1;
                        o_nx_waddr = AW'(r_tmp);
                        o_nx_wdata = r_tmp;
                        o_pv_we    = 1'b1;
                        o_pv_waddr = AW'(r_tmp);
                        o_pv_wdata = r_tmp;
                    end
                    o_nx_raddr = AW'(lnk_a);
                    n_tmp      = lnk_a;
                    n_k        = r_k - LW'(1);
                end
            end

            // hand the word to the output register once it is free
            ST_DONE: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_res     = RES_W'(r_res);
                    n_o_present = r_present;
                    n_o_first   = (r_count != '0) ? FL_W'(r_head_first) : '0;
                    n_o_last    = (r_count != '0) ? FL_W'(r_head_last) : '0;
                    n_o_empty   = (r_count == '0);
                    n_o_count   = CNT_W'(r_count);
                    n_o_err     = r_err;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_result_node    = r_o_res;
    assign o_result_present = r_o_present;
    assign o_first_node     = r_o_first;
    assign o_last_node      = r_o_last;
    assign o_list_empty     = r_o_empty;
    assign o_node_count     = r_o_count;
    assign o_count_error    = r_o_err;

    // Checks
    `ASSERT_CLKRST(a_count_bound, i_clk, i_rst_n, r_count <= SENT, "node count above pool size")
    `ASSERT_CLK(a_reset_state, i_clk, $past(!i_rst_n) |-> (r_state == ST_IDLE && !r_o_valid), "sequencer not idle after reset")
    `ASSERT_CLKRST(a_accept_leaves_idle, i_clk, i_rst_n, in_acc |=> (r_state != ST_IDLE), "accepted word did not start the sequencer")
    `ASSERT_CLKRST(a_walk_step, i_clk, i_rst_n, (r_state == ST_WALK && r_k != '0) |=> (r_state == ST_WALK && r_k == $past(r_k) - LW'(1)), "clear walk lost a step")
    `ASSERT_CLKRST(a_done_holds, i_clk, i_rst_n, (r_state == ST_DONE && r_o_valid && i_stall) |=> (r_state == ST_DONE && $stable(r_res)), "finished word dropped while output stalled")

endmodule

// File: rtl/core/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Circular doubly linked list over a pool of NODES nodes with a head
// sentinel (index NODES); links held in two synchronous memories.
// ----------------------------------------------------------------------------
// Use: the command channel (i_valid / o_stall) takes one word of command,
// node and anchor; the result channel (o_valid / i_stall) returns exactly
// one word per command: the removed or neighbouring node with its present
// flag, plus first node, last node, empty flag, count and count error.
// Steps: init, remove first, remove, next and previous: EXEC, DONE; add
// first, add last and insert after: EXEC, EXEC2, DONE; ignored: DONE; clear
// all: WALK, DONE. A command is accepted again the cycle after its result is
// loaded. Each step is one read-modify-write of the forward and backward
// link memories (one read and one write port each, registered read); clear
// all frees one node per cycle. Reset clears the sentinel to point at
// itself and the count to zero; the link memories are not cleared, and the
// user must see that a node's links are read only after they have been
// written; the block does not enforce it. When the receiver stalls, the
// result word waits in the output register while the next command is taken
// and worked on; it then waits at its end until the register is free.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node,
    input  logic [ANCH_W-1:0] i_anchor,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RES_W-1:0]  o_result_node,
    output logic              o_result_present,
    output logic [FL_W-1:0]   o_first_node,
    output logic [FL_W-1:0]   o_last_node,
    output logic              o_list_empty,
    output logic [CNT_W-1:0]  o_node_count,
    output logic              o_count_error
);

    localparam int LW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);

    logic          nx_we, pv_we;
    logic [AW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

    // Command sequencer
    dllm_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_node           (i_node),
        .i_anchor         (i_anchor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_node    (o_result_node),
        .o_result_present (o_result_present),
        .o_first_node     (o_first_node),
        .o_last_node      (o_last_node),
        .o_list_empty     (o_list_empty),
        .o_node_count     (o_node_count),
        .o_count_error    (o_count_error),
        .o_nx_we          (nx_we),
        .o_nx_waddr       (nx_waddr),
        .o_nx_wdata       (nx_wdata),
        .o_nx_raddr       (nx_raddr),
        .i_nx_rdata       (nx_rdata),
        .o_pv_we          (pv_we),
        .o_pv_waddr       (pv_waddr),
        .o_pv_wdata       (pv_wdata),
        .o_pv_raddr       (pv_raddr),
        .i_pv_rdata       (pv_rdata)
    );

    // Forward links
    dllm_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    // Backward links
    dllm_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

endmodule

// File: sim/tb_doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_manager
// Self-checking bench for the circular doubly linked list manager. A short
// scripted run covers the empty list, saturation of the count at zero, the
// sentinel as anchor and as neighbour, every command and ignored commands.
// Random traffic follows: mostly well-formed list operations with alternating
// fill and drain bias, plus noise. Each command word is predicted by a local
// model of the links, and every result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_manager;
    import dllm_pkg::*;

    localparam int NODES = NODES_DEF;
    localparam logic [ANCH_W-1:0] HEAD = ANCH_W'(NODES);
    localparam int RANDOM_WORDS = 1650;
    localparam int BIAS_SPAN = 250;

    // Command codes outside the defined set
    localparam logic [CMD_W-1:0] CMD_VOID_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_VOID_HI = 4'd15;

    typedef struct packed {
        logic [RES_W-1:0] res_node;
        logic             present;
        logic [FL_W-1:0]  first_nd;
        logic [FL_W-1:0]  last_nd;
        logic             empty;
        logic [CNT_W-1:0] count;
        logic             cnt_err;
    } t_word;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node;
        logic [ANCH_W-1:0] anchor;
        logic              typed;
        t_word             want;
    } t_row;

    localparam t_word NO_WANT     = '0;
    localparam t_word QUIET_EMPTY = '{7'd0, 1'b0, 6'd0, 6'd0, 1'b1, 7'd0, 1'b0};
    localparam t_word UNDERFLOW_0 = '{7'd0, 1'b1, 6'd0, 6'd0, 1'b1, 7'd0, 1'b1};
    localparam t_word LONE_63     = '{7'd0, 1'b0, 6'd63, 6'd63, 1'b0, 7'd1, 1'b0};

    // Scripted opening; typed rows carry their own expected word
    localparam t_row SCRIPT [0:25] = '{
        '{CMD_REM_FIRST, 6'd0,  7'd0,   1'b1, QUIET_EMPTY},
        '{CMD_CLEAR,     6'd0,  7'd0,   1'b1, QUIET_EMPTY},
        '{CMD_INIT,      6'd0,  7'd0,   1'b1, QUIET_EMPTY},
        '{CMD_REMOVE,    6'd0,  7'd0,   1'b1, UNDERFLOW_0},
        '{CMD_NEXT,      6'd0,  7'd0,   1'b1, QUIET_EMPTY},
        '{CMD_PREV,      6'd0,  7'd0,   1'b1, QUIET_EMPTY},
        '{CMD_ADD_FIRST, 6'd63, 7'd0,   1'b1, LONE_63},
        '{CMD_ADD_LAST,  6'd0,  7'd0,   1'b0, NO_WANT},
        '{CMD_INS_AFTER, 6'd5,  HEAD,   1'b0, NO_WANT},
        '{CMD_INS_AFTER, 6'd10, 7'd0,   1'b0, NO_WANT},
        '{CMD_INS_AFTER, 6'd20, 7'd63,  1'b0, NO_WANT},
        '{CMD_NEXT,      6'd10, 7'd0,   1'b0, NO_WANT},
        '{CMD_PREV,      6'd5,  7'd0,   1'b0, NO_WANT},
        '{CMD_NEXT,      6'd63, 7'd0,   1'b0, NO_WANT},
        '{CMD_PREV,      6'd63, 7'd0,   1'b0, NO_WANT},
        '{CMD_INS_AFTER, 6'd30, 7'd65,  1'b0, NO_WANT},
        '{CMD_INS_AFTER, 6'd31, 7'd127, 1'b0, NO_WANT},
        '{CMD_VOID_LO,   6'd63, 7'd127, 1'b0, NO_WANT},
        '{CMD_VOID_HI,   6'd0,  7'd0,   1'b0, NO_WANT},
        '{CMD_REMOVE,    6'd20, 7'd0,   1'b0, NO_WANT},
        '{CMD_REM_FIRST, 6'd0,  7'd0,   1'b0, NO_WANT},
        '{CMD_ADD_FIRST, 6'd42, 7'd0,   1'b0, NO_WANT},
        '{CMD_CLEAR,     6'd0,  7'd0,   1'b0, NO_WANT},
        '{CMD_NEXT,      6'd63, 7'd0,   1'b0, NO_WANT},
        '{CMD_ADD_LAST,  6'd42, 7'd0,   1'b0, NO_WANT},
        '{CMD_REM_FIRST, 6'd0,  7'd0,   1'b0, NO_WANT}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command = '0;
    logic [NODE_W-1:0] i_node = '0;
    logic [ANCH_W-1:0] i_anchor = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [RES_W-1:0]  o_result_node;
    logic              o_result_present;
    logic [FL_W-1:0]   o_first_node;
    logic [FL_W-1:0]   o_last_node;
    logic              o_list_empty;
    logic [CNT_W-1:0]  o_node_count;
    logic              o_count_error;

    // Local copy of the link state
    logic [ANCH_W-1:0] fwd_link [0:NODES-1];
    logic [ANCH_W-1:0] bwd_link [0:NODES-1];
    bit                fwd_known [0:NODES-1];
    bit                bwd_known [0:NODES-1];
    logic [ANCH_W-1:0] head_first_q = HEAD;
    logic [ANCH_W-1:0] head_last_q = HEAD;
    logic [CNT_W-1:0]  count_q = '0;

    t_word       expected_words [$];
    t_word       oldest_word;
    int unsigned tx_idle_pct = 11;
    int unsigned rx_idle_pct = 86;
    int          mismatches = 0;

    doubly_linked_list_manager #(
        .NODES (NODES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_node           (i_node),
        .i_anchor         (i_anchor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_node    (o_result_node),
        .o_result_present (o_result_present),
        .o_first_node     (o_first_node),
        .o_last_node      (o_last_node),
        .o_list_empty     (o_list_empty),
        .o_node_count     (o_node_count),
        .o_count_error    (o_count_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Link access; index NODES is the sentinel, held in the head registers
    function automatic logic [ANCH_W-1:0] link_fwd(logic [ANCH_W-1:0] i);
        return (i < HEAD) ? fwd_link[i] : head_first_q;
    endfunction

    function automatic logic [ANCH_W-1:0] link_bwd(logic [ANCH_W-1:0] i);
        return (i < HEAD) ? bwd_link[i] : head_last_q;
    endfunction

    function automatic void put_fwd(logic [ANCH_W-1:0] i, logic [ANCH_W-1:0] v);
        if (i < HEAD) begin
            fwd_link[i]  = v;
            fwd_known[i] = 1'b1;
        end else begin
            head_first_q = v;
        end
    endfunction

    function automatic void put_bwd(logic [ANCH_W-1:0] i, logic [ANCH_W-1:0] v);
        if (i < HEAD) begin
            bwd_link[i]  = v;
            bwd_known[i] = 1'b1;
        end else begin
            head_last_q = v;
        end
    endfunction

    // Saturating count; returns the error flag
    function automatic bit count_up();
        if (count_q >= NODES) return 1'b1;
        count_q++;
        return 1'b0;
    endfunction

    function automatic bit count_down();
        if (count_q == 0) return 1'b1;
        count_q--;
        return 1'b0;
    endfunction

    // Applies one command to the local list and returns the word it yields
    function automatic t_word predict_list_op(logic [CMD_W-1:0] cmd,
                                              logic [NODE_W-1:0] nd_in,
                                              logic [ANCH_W-1:0] an);
        t_word             w;
        logic [ANCH_W-1:0] nd;
        logic [ANCH_W-1:0] f;
        logic [ANCH_W-1:0] l;
        logic [ANCH_W-1:0] p;
        logic [ANCH_W-1:0] nx;
        logic [ANCH_W-1:0] cur;
        w  = '0;
        nd = {1'b0, nd_in};
        case (cmd)
            CMD_INIT: begin
                put_fwd(nd, nd);
                put_bwd(nd, nd);
            end
            CMD_CLEAR: begin
                cur = head_first_q;
                for (int k = count_q; k != 0; k--) begin
                    nx = link_fwd(cur);
                    put_fwd(cur, cur);
                    put_bwd(cur, cur);
                    cur = nx;
                end
                head_first_q = HEAD;
                head_last_q  = HEAD;
                count_q      = '0;
            end
            CMD_ADD_FIRST: begin
                f = head_first_q;
                put_bwd(nd, link_bwd(f));
                put_fwd(nd, f);
                put_bwd(f, nd);
                head_first_q = nd;
                w.cnt_err = count_up();
            end
            CMD_ADD_LAST: begin
                l = head_last_q;
                put_fwd(nd, HEAD);
                put_bwd(nd, l);
                put_fwd(l, nd);
                head_last_q = nd;
                w.cnt_err = count_up();
            end
            CMD_REM_FIRST: begin
                if (count_q != 0) begin
                    f  = head_first_q;
                    nx = link_fwd(f);
                    put_bwd(nx, HEAD);
                    head_first_q = nx;
                    count_q--;
                    w.res_node = f;
                    w.present  = 1'b1;
                end
            end
            CMD_INS_AFTER: begin
                if (an <= HEAD) begin
                    nx = link_fwd(an);
                    put_bwd(nd, an);
                    put_fwd(nd, nx);
                    put_bwd(nx, nd);
                    put_fwd(an, nd);
                    w.cnt_err = count_up();
                end
            end
            CMD_REMOVE: begin
                p  = link_bwd(nd);
                nx = link_fwd(nd);
                put_fwd(p, nx);
                put_bwd(nx, p);
                w.cnt_err  = count_down();
                w.res_node = nd;
                w.present  = 1'b1;
            end
            CMD_NEXT, CMD_PREV: begin
                l = (cmd == CMD_NEXT) ? link_fwd(nd) : link_bwd(nd);
                if (l != nd) begin
                    w.res_node = l;
                    w.present  = 1'b1;
                end
            end
            default: ;
        endcase
        w.first_nd = (count_q != 0) ? head_first_q[FL_W-1:0] : '0;
        w.last_nd  = (count_q != 0) ? head_last_q[FL_W-1:0] : '0;
        w.empty    = (count_q == 0);
        w.count    = count_q;
        return w;
    endfunction

    // True when the command touches only links that have been written
    function automatic bit reads_written(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] nd,
                                         logic [ANCH_W-1:0] an);
        logic [ANCH_W-1:0] walk_fwd [0:NODES-1];
        bit                walk_known [0:NODES-1];
        int                cur;
        int                nxt;
        int                hf;
        walk_fwd   = fwd_link;
        walk_known = fwd_known;
        case (cmd)
            CMD_CLEAR: begin
                // dry run of the walk, which rewrites links as it goes
                cur = head_first_q;
                hf  = head_first_q;
                for (int k = count_q; k != 0; k--) begin
                    if (cur < NODES) begin
                        if (!walk_known[cur]) return 1'b0;
                        nxt = walk_fwd[cur];
                        walk_fwd[cur]   = ANCH_W'(cur);
                        walk_known[cur] = 1'b1;
                    end else begin
                        nxt = hf;
                        hf  = NODES;
                    end
                    cur = nxt;
                end
                return 1'b1;
            end
            CMD_ADD_FIRST: return head_first_q == HEAD || bwd_known[head_first_q];
            CMD_REM_FIRST:
                return count_q == 0 || head_first_q == HEAD || fwd_known[head_first_q];
            CMD_INS_AFTER: return an >= HEAD || fwd_known[an];
            CMD_REMOVE:    return fwd_known[nd] && bwd_known[nd];
            CMD_NEXT:      return fwd_known[nd];
            CMD_PREV:      return bwd_known[nd];
            default:       return 1'b1;
        endcase
    endfunction

    // Random command: mostly well-formed against the current list, some noise
    task automatic pick_command(input bit grow, output logic [CMD_W-1:0] cmd,
                                output logic [NODE_W-1:0] nd, output logic [ANCH_W-1:0] an);
        bit linked [0:NODES-1];
        int members [$];
        int spare [$];
        int cur;
        int roll;
        cur = head_first_q;
        for (int k = 0; k < count_q && cur < NODES; k++) begin
            if (!fwd_known[cur] || linked[cur]) break;
            linked[cur] = 1'b1;
            members.push_back(cur);
            cur = fwd_link[cur];
        end
        for (int i = 0; i < NODES; i++) begin
            if (!linked[i]) spare.push_back(i);
        end
        for (int t = 0; t < 32; t++) begin
            cmd  = CMD_INIT;
            nd   = $urandom_range(NODES - 1);
            an   = $urandom_range(NODES);
            roll = $urandom_range(99);
            if ($urandom_range(4) == 0) begin
                cmd = $urandom_range(15);
                if ($urandom_range(1) != 0) an = $urandom_range(127);
            end else if (roll < (grow ? 55 : 15)) begin
                // a full pool leaves only re-adds of linked nodes
                if (spare.size() != 0) nd = spare[$urandom_range(spare.size() - 1)];
                else if (members.size() != 0) nd = members[$urandom_range(members.size() - 1)];
                case ($urandom_range(2))
                    0: cmd = CMD_ADD_FIRST;
                    1: cmd = CMD_ADD_LAST;
                    default: begin
                        cmd = CMD_INS_AFTER;
                        if (members.size() != 0 && $urandom_range(3) != 0)
                            an = members[$urandom_range(members.size() - 1)];
                        else
                            an = HEAD;
                    end
                endcase
            end else if (roll < (grow ? 63 : 55)) begin
                cmd = ($urandom_range(1) != 0) ? CMD_REM_FIRST : CMD_REMOVE;
                if (members.size() != 0) nd = members[$urandom_range(members.size() - 1)];
            end else if (roll < 85) begin
                cmd = ($urandom_range(1) != 0) ? CMD_NEXT : CMD_PREV;
                if (members.size() != 0 && $urandom_range(3) != 0)
                    nd = members[$urandom_range(members.size() - 1)];
            end else if (roll < 97 || grow) begin
                cmd = CMD_INIT;
                if (spare.size() != 0) nd = spare[$urandom_range(spare.size() - 1)];
            end else begin
                cmd = CMD_CLEAR;
            end
            if (reads_written(cmd, nd, an)) return;
        end
        // init never reads a link
        cmd = CMD_INIT;
    endtask

    // Offers one command word and records its expected result once taken
    task automatic issue_command(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] nd,
                                 logic [ANCH_W-1:0] an, logic typed, t_word want);
        t_word model_word;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node    <= nd;
        i_anchor  <= an;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model_word = predict_list_op(cmd, nd, an);
        expected_words.push_back(typed ? want : model_word);
    endtask

    task automatic note_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Result side: check each taken word, then choose the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected word", 1, 0);
            end else begin
                oldest_word = expected_words.pop_front();
                if (o_result_node !== oldest_word.res_node)
                    note_mismatch("result_node", o_result_node, oldest_word.res_node);
                if (o_result_present !== oldest_word.present)
                    note_mismatch("result_present", o_result_present, oldest_word.present);
                if (o_first_node !== oldest_word.first_nd)
                    note_mismatch("first_node", o_first_node, oldest_word.first_nd);
                if (o_last_node !== oldest_word.last_nd)
                    note_mismatch("last_node", o_last_node, oldest_word.last_nd);
                if (o_list_empty !== oldest_word.empty)
                    note_mismatch("list_empty", o_list_empty, oldest_word.empty);
                if (o_node_count !== oldest_word.count)
                    note_mismatch("node_count", o_node_count, oldest_word.count);
                if (o_count_error !== oldest_word.cnt_err)
                    note_mismatch("count_error", o_count_error, oldest_word.cnt_err);
            end
        end
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Command side and end of run
    initial begin
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] nd;
        logic [ANCH_W-1:0] an;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (SCRIPT[r]) begin
            issue_command(SCRIPT[r].cmd, SCRIPT[r].node, SCRIPT[r].anchor,
                          SCRIPT[r].typed, SCRIPT[r].want);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                tx_idle_pct = 86;
                rx_idle_pct = 11;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // alternate between filling the pool and draining it
            pick_command(((n / BIAS_SPAN) % 2) == 0, cmd, nd, an);
            issue_command(cmd, nd, an, 1'b0, NO_WANT);
        end
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (NODES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dllm_pkg.sv
rtl/core/dllm_ram.sv
rtl/core/dllm_ctrl.sv
rtl/core/doubly_linked_list_manager.sv
sim/tb_doubly_linked_list_manager.sv
